// File: hdl/c3bl_pkg.sv
// shared constants, types and register codes of the 3x3 filter
`timescale 1ns / 1ps
`default_nettype none

package c3bl_pkg;

    // image limits
    localparam int unsigned MAX_WIDTH  = 1024;
    localparam int unsigned MAX_HEIGHT = 1024;

    // field widths
    localparam int unsigned PIX_W     = 8;
    localparam int unsigned CFG_W     = 11;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
    localparam int unsigned DIM_W     = $clog2(MAX_WIDTH + 1);
    localparam int unsigned HGT_W     = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned ROW_W     = $clog2(MAX_HEIGHT + 2);

    // reset geometry, clamped to the limits
    localparam int unsigned RESET_WIDTH  = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
    localparam int unsigned RESET_HEIGHT = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

    localparam logic [PIX_W-1:0] BORDER = 8'hFF;

    // kernel arithmetic
    localparam int unsigned SUM_W       = 12;
    localparam int unsigned LAP_W       = 11;
    localparam int unsigned RECIP_W     = 11;
    localparam int unsigned RECIP_SHIFT = 14;
    localparam int unsigned RECIP_9     = 1821;  // ceil(2^14 / 9), exact below 3276

    // result queue
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 3);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_MODE  = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2
    } t_cfg_idx;

    localparam logic MODE_BLUR    = 1'b0;
    localparam logic MODE_LAPLACE = 1'b1;

    typedef struct packed {
        logic             rd_en;
        logic [COL_W-1:0] rd_col;
        logic             wr_en;
        logic [COL_W-1:0] wr_col;
        logic [PIX_W-1:0] wr_upper;
        logic [PIX_W-1:0] wr_middle;
    } t_ls_req;

    typedef struct packed {
        logic [PIX_W-1:0] upper;
        logic [PIX_W-1:0] middle;
    } t_ls_rsp;

    typedef struct packed {
        logic [PIX_W-1:0] filtered_pixel;
        logic             end_of_image;
    } t_res;

endpackage

`default_nettype wire

// File: hdl/c3bl_pix_if.sv
// source pixel channel
`timescale 1ns / 1ps
`default_nettype none

interface c3bl_pix_if;
    import c3bl_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_value;
    logic             flush;

    modport source (output valid, output pixel_value, output flush, input ready);
    modport sink   (input valid, input pixel_value, input flush, output ready);
endinterface

`default_nettype wire

// File: hdl/c3bl_res_if.sv
// filtered pixel channel
`timescale 1ns / 1ps
`default_nettype none

interface c3bl_res_if;
    import c3bl_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] filtered_pixel;
    logic             end_of_image;

    modport source (output valid, output filtered_pixel, output end_of_image, input ready);
    modport sink   (input valid, input filtered_pixel, input end_of_image, output ready);
endinterface

`default_nettype wire

// File: hdl/c3bl_line_store.sv
// two row buffers with registered read and write-to-read forwarding
`timescale 1ns / 1ps
`default_nettype none

module c3bl_line_store (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire c3bl_pkg::t_ls_req  i_req,
    output c3bl_pkg::t_ls_rsp       o_rsp
);
    import c3bl_pkg::*;

    logic [PIX_W-1:0] mem_upper  [MAX_WIDTH];
    logic [PIX_W-1:0] mem_middle [MAX_WIDTH];

    logic [PIX_W-1:0] r_rd_upper;
    logic [PIX_W-1:0] r_rd_middle;
    logic [PIX_W-1:0] r_fwd_upper;
    logic [PIX_W-1:0] r_fwd_middle;
    logic             r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem_upper[i_req.wr_col]  <= i_req.wr_upper;
            mem_middle[i_req.wr_col] <= i_req.wr_middle;
        end
        if (i_req.rd_en) begin
            r_rd_upper  <= mem_upper[i_req.rd_col];
            r_rd_middle <= mem_middle[i_req.rd_col];
        end
    end

    // same column written and read in one cycle: hand over the new data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_req.rd_en) begin
            r_fwd <= i_req.wr_en && (i_req.wr_col == i_req.rd_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_fwd_upper  <= i_req.wr_upper;
            r_fwd_middle <= i_req.wr_middle;
        end
    end

    assign o_rsp.upper  = r_fwd ? r_fwd_upper  : r_rd_upper;
    assign o_rsp.middle = r_fwd ? r_fwd_middle : r_rd_middle;

endmodule

`default_nettype wire

// File: hdl/conv3x3_blur_or_laplacian.sv
// 3x3 box blur / laplacian filter over a raster pixel stream
`timescale 1ns / 1ps
`default_nettype none

// usage
//   i_pix : source words in raster order, pixel_value plus flush; a flush word
//           carries no pixel and is dropped while image pixels are still due
//   o_res : one filtered word per source pixel, raster order, end_of_image
//           marks the last one; W+1 flush words after the W*H pixels drain it
//   config: i_cfg_we / i_cfg_idx / i_cfg_data, written only while idle;
//           index 0 filter mode, 1 width, 2 height; any listed write restarts
//           the image, zero dimensions count as one, large ones saturate
// timing
//   one word accepted every clock while i_pix.ready is high; the result for pixel t
//   belongs to word t+W+1 and is valid once that word has passed the line store
//   read, the kernel sum and the divide/clamp into the result queue
//   the line stores are synchronous rams with registered read, read at the current
//   column and written at the previous word's column; a same-column hit is forwarded
// reset and stall
//   reset gives blur mode, 640x480, counters at zero and the window at border
//   value; rows above the image ignore what the stores return, so no clearing pass
//   a four-word result queue absorbs the two words in flight; i_pix.ready
//   drops when it could overfill and rises again as words are taken

module conv3x3_blur_or_laplacian (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    c3bl_pix_if.sink                               i_pix,
    c3bl_res_if.source                             o_res,
    input  wire logic                              i_cfg_we,
    input  wire logic [c3bl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [c3bl_pkg::CFG_W-1:0]        i_cfg_data
);
    import c3bl_pkg::*;

    localparam int unsigned PROD_W = SUM_W + RECIP_W;

    // configuration
    logic             r_mode;
    logic [DIM_W-1:0] r_width;
    logic [HGT_W-1:0] r_height;
    logic             cfg_restart;
    logic [DIM_W-1:0] cfg_width;
    logic [HGT_W-1:0] cfg_height;

    // position counters
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;

    // stage 0 decode
    logic             accept;
    logic             in_image;
    logic             op;
    logic             at_last;
    logic             emit;
    logic             row_end;
    logic [PIX_W-1:0] pix_in;

    // stage 1: line store data back, window update, kernel sums
    logic             r_s1_valid;
    logic [COL_W-1:0] r_s1_col;
    logic [PIX_W-1:0] r_s1_v;
    logic             r_s1_ge1;
    logic             r_s1_ge2;
    logic             r_s1_col0;
    logic             r_s1_emit;
    logic             r_s1_last;

    t_ls_req          ls_req;
    t_ls_rsp          ls_rsp;
    logic [PIX_W-1:0] up1;
    logic [PIX_W-1:0] mid1;

    // window columns 1 and 2, rows top to bottom; column 0 is never read back
    logic [PIX_W-1:0] r_win1 [3];
    logic [PIX_W-1:0] r_win2 [3];
    logic [PIX_W-1:0] ncol   [3];
    logic [PIX_W-1:0] a0     [3];
    logic [PIX_W-1:0] a1     [3];
    logic [SUM_W-1:0] blur_sum;
    logic [LAP_W-1:0] lap_diff;

    // stage 2: divide by nine or clamp
    logic             r_s2_valid;
    logic             r_s2_last;
    logic [SUM_W-1:0] r_s2_sum;
    logic [LAP_W-1:0] r_s2_lap;
    logic [PROD_W-1:0] blur_prod;
    logic [PIX_W-1:0] lap_pix;
    t_res             s2_res;

    // result queue
    t_res               r_q_data [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_q_wr;
    logic [Q_PTR_W-1:0] r_q_rd;
    logic [Q_CNT_W-1:0] r_q_cnt;
    logic [Q_CNT_W-1:0] inflight;
    logic               q_push;
    logic               q_pop;

    // ---------------------------------------------------------------- config

    always_comb begin
        cfg_width  = (i_cfg_data == '0) ? DIM_W'(1)
                   : (32'(i_cfg_data) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH)
                   : DIM_W'(i_cfg_data);
        cfg_height = (i_cfg_data == '0) ? HGT_W'(1)
                   : (32'(i_cfg_data) > MAX_HEIGHT) ? HGT_W'(MAX_HEIGHT)
                   : HGT_W'(i_cfg_data);
        unique case (t_cfg_idx'(i_cfg_idx))
            CFG_FILTER_MODE, CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT: begin
                cfg_restart = i_cfg_we;
            end
            default: begin
                cfg_restart = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_BLUR;
            r_width  <= DIM_W'(RESET_WIDTH);
            r_height <= HGT_W'(RESET_HEIGHT);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FILTER_MODE: begin
                    r_mode <= i_cfg_data[0];
                end
                CFG_IMAGE_WIDTH: begin
                    r_width <= cfg_width;
                end
                CFG_IMAGE_HEIGHT: begin
                    r_height <= cfg_height;
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- stage 0

    assign accept   = i_pix.valid && i_pix.ready;
    assign in_image = r_row < ROW_W'(r_height);
    assign op       = accept && !(in_image && i_pix.flush);
    assign pix_in   = in_image ? i_pix.pixel_value : BORDER;
    assign at_last  = (r_row == ROW_W'(r_height) + ROW_W'(1)) && (r_col == '0);
    assign emit     = (r_row >= ROW_W'(2)) || ((r_row == ROW_W'(1)) && (r_col != '0));
    assign row_end  = (DIM_W'(r_col) + DIM_W'(1)) == r_width;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (cfg_restart) begin
            n_col = '0;
            n_row = '0;
        end else if (op) begin
            if (at_last) begin
                n_col = '0;
                n_row = '0;
            end else if (row_end) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_s1_valid <= op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (op) begin
            r_s1_col  <= r_col;
            r_s1_v    <= pix_in;
            r_s1_ge1  <= r_row != '0;
            r_s1_ge2  <= r_row >= ROW_W'(2);
            r_s1_col0 <= r_col == '0;
            r_s1_emit <= emit;
            r_s1_last <= at_last;
        end
    end

    // ---------------------------------------------------------------- line store

    always_comb begin
        ls_req.rd_en     = op;
        ls_req.rd_col    = r_col;
        ls_req.wr_en     = r_s1_valid;
        ls_req.wr_col    = r_s1_col;
        ls_req.wr_upper  = mid1;
        ls_req.wr_middle = r_s1_v;
    end

    c3bl_line_store u_line_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ls_req),
        .o_rsp   (ls_rsp)
    );

    // ---------------------------------------------------------------- stage 1

    // rows above the image are border
    assign up1  = r_s1_ge2 ? ls_rsp.upper  : BORDER;
    assign mid1 = r_s1_ge1 ? ls_rsp.middle : BORDER;

    always_comb begin
        // incoming right column, border at the start of a row
        ncol[0] = r_s1_col0 ? BORDER : up1;
        ncol[1] = r_s1_col0 ? BORDER : mid1;
        ncol[2] = r_s1_col0 ? BORDER : r_s1_v;
        for (int r = 0; r < 3; r++) begin
            a0[r] = r_win1[r];
            a1[r] = r_win2[r];
        end
        blur_sum = SUM_W'(a0[0]) + SUM_W'(a0[1]) + SUM_W'(a0[2])
                 + SUM_W'(a1[0]) + SUM_W'(a1[1]) + SUM_W'(a1[2])
                 + SUM_W'(ncol[0]) + SUM_W'(ncol[1]) + SUM_W'(ncol[2]);
        // up + down + left + right - 4 * centre, two's complement
        lap_diff = LAP_W'(a1[0]) + LAP_W'(a1[2]) + LAP_W'(a0[1]) + LAP_W'(ncol[1])
                 - LAP_W'({a1[1], 2'b00});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_restart) begin
            for (int r = 0; r < 3; r++) begin
                r_win1[r] <= BORDER;
                r_win2[r] <= BORDER;
            end
        end else if (r_s1_valid) begin
            if (r_s1_last) begin
                for (int r = 0; r < 3; r++) begin
                    r_win1[r] <= BORDER;
                    r_win2[r] <= BORDER;
                end
            end else begin
                r_win1[0] <= r_s1_col0 ? BORDER : r_win2[0];
                r_win1[1] <= r_s1_col0 ? BORDER : r_win2[1];
                r_win1[2] <= r_s1_col0 ? BORDER : r_win2[2];
                r_win2[0] <= up1;
                r_win2[1] <= mid1;
                r_win2[2] <= r_s1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_s2_last <= r_s1_last;
            r_s2_sum  <= blur_sum;
            r_s2_lap  <= lap_diff;
        end
    end

    // ---------------------------------------------------------------- stage 2

    // divide by nine through the reciprocal
    assign blur_prod = PROD_W'(r_s2_sum) * PROD_W'(RECIP_9);

    always_comb begin
        if (r_s2_lap[LAP_W-1]) begin
            lap_pix = '0;
        end else if (r_s2_lap[LAP_W-2:PIX_W] != '0) begin
            lap_pix = BORDER;
        end else begin
            lap_pix = r_s2_lap[PIX_W-1:0];
        end
        s2_res.filtered_pixel = (r_mode == MODE_LAPLACE) ? lap_pix
                              : blur_prod[RECIP_SHIFT +: PIX_W];
        s2_res.end_of_image   = r_s2_last;
    end

    // ---------------------------------------------------------------- result queue

    assign q_push   = r_s2_valid;
    assign q_pop    = o_res.valid && o_res.ready;
    assign inflight = r_q_cnt + Q_CNT_W'(r_s1_valid) + Q_CNT_W'(r_s2_valid);

    // room for both words in flight plus the new one
    assign i_pix.ready = inflight < Q_CNT_W'(Q_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wr  <= '0;
            r_q_rd  <= '0;
            r_q_cnt <= '0;
        end else begin
            if (q_push) begin
                r_q_wr <= r_q_wr + Q_PTR_W'(1);
            end
            if (q_pop) begin
                r_q_rd <= r_q_rd + Q_PTR_W'(1);
            end
            r_q_cnt <= r_q_cnt + Q_CNT_W'(q_push) - Q_CNT_W'(q_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_push) begin
            r_q_data[r_q_wr] <= s2_res;
        end
    end

    assign o_res.valid          = r_q_cnt != '0;
    assign o_res.filtered_pixel = r_q_data[r_q_rd].filtered_pixel;
    assign o_res.end_of_image   = r_q_data[r_q_rd].end_of_image;

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// self-checking bench for the 3x3 blur / laplacian filter, predictor and stimulus
`timescale 1ns / 1ps

module tb_top;
    import c3bl_pkg::*;

    localparam int unsigned CLK_HALF      = 5;
    localparam int unsigned RESET_CYCLES  = 5;
    localparam int unsigned SETTLE_CYCLES = 8;     // wait after the last expected word, with slack
    localparam int unsigned QUIET_LIMIT   = 2000;  // cycles with no word moving
    localparam int unsigned WORD_TARGET   = 500;
    localparam int unsigned SMALL_W_MAX   = 12;
    localparam int unsigned SMALL_H_MAX   = 6;

    // index with no register behind it, writes to it change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNLISTED = 2'd3;

    // pixel flavours for random images
    typedef enum int {
        PIX_UNIFORM,
        PIX_EXTREME,
        PIX_NEAR_RAILS
    } t_pix_style;

    // predictor, expected-word store and checker in one place
    class conv_scoreboard;
        logic             mode;
        logic [CFG_W-1:0] width_reg;
        logic [CFG_W-1:0] height_reg;
        logic [PIX_W-1:0] upper_row  [MAX_WIDTH];
        logic [PIX_W-1:0] middle_row [MAX_WIDTH];
        logic [PIX_W-1:0] win        [3][3];
        int unsigned      col_cnt;
        int unsigned      row_cnt;
        t_res             expected_px[$];
        int unsigned      errors;
        int unsigned      words_used;
        int unsigned      words_ignored;
        int unsigned      words_checked;
        int unsigned      images_done;

        function new();
            mode          = MODE_BLUR;
            width_reg     = CFG_W'(RESET_WIDTH);
            height_reg    = CFG_W'(RESET_HEIGHT);
            errors        = 0;
            words_used    = 0;
            words_ignored = 0;
            words_checked = 0;
            images_done   = 0;
            restart_image();
        endfunction

        function int unsigned dim_in_range(logic [CFG_W-1:0] v, int unsigned maxv);
            if (v == 0) return 1;
            if (v > maxv) return maxv;
            return v;
        endfunction

        function void restart_image();
            for (int k = 0; k < 3; k++)
                for (int j = 0; j < 3; j++)
                    win[k][j] = BORDER;
            col_cnt = 0;
            row_cnt = 0;
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_FILTER_MODE:  mode = data[0];
                CFG_IMAGE_WIDTH:  width_reg = data;
                CFG_IMAGE_HEIGHT: height_reg = data;
                default:          return;
            endcase
            restart_image();
        endfunction

        function logic [PIX_W-1:0] filter_window(logic [PIX_W-1:0] a [3][3]);
            int unsigned sum;
            int          lap;
            if (mode == MODE_BLUR) begin
                sum = 0;
                for (int k = 0; k < 3; k++)
                    for (int j = 0; j < 3; j++)
                        sum += a[k][j];
                return PIX_W'(sum / 9);
            end
            lap = int'(a[0][1]) + int'(a[2][1]) + int'(a[1][0]) + int'(a[1][2])
                - 4 * int'(a[1][1]);
            if (lap < 0) lap = 0;
            if (lap > 255) lap = 255;
            return PIX_W'(lap);
        endfunction

        // one accepted source word: advance the window and queue its filtered word
        function void note_word(logic [PIX_W-1:0] pv, logic fl);
            int unsigned      w;
            int unsigned      h;
            int unsigned      total;
            int unsigned      slot;
            int unsigned      last_slot;
            int unsigned      col;
            logic [PIX_W-1:0] v;
            logic [PIX_W-1:0] up;
            logic [PIX_W-1:0] mid;
            logic [PIX_W-1:0] a [3][3];
            t_res             res;
            w         = dim_in_range(width_reg, MAX_WIDTH);
            h         = dim_in_range(height_reg, MAX_HEIGHT);
            total     = w * h;
            col       = col_cnt;
            slot      = row_cnt * w + col;
            last_slot = total + w;

            if (slot < total) begin
                // a flush while pixels are still due is dropped
                if (fl) begin
                    words_ignored++;
                    return;
                end
                v = pv;
            end else begin
                // drain slot, a pixel here counts as a flush
                v = BORDER;
            end
            words_used++;

            up  = (row_cnt >= 2) ? upper_row[col]  : BORDER;
            mid = (row_cnt >= 1) ? middle_row[col] : BORDER;

            for (int k = 0; k < 3; k++) begin
                a[k][0] = win[k][1];
                a[k][1] = win[k][2];
            end
            if (col == 0) begin
                for (int k = 0; k < 3; k++) a[k][2] = BORDER;
            end else begin
                a[0][2] = up;
                a[1][2] = mid;
                a[2][2] = v;
            end

            if (slot >= w + 1) begin
                res.filtered_pixel = filter_window(a);
                res.end_of_image   = (slot == last_slot);
                expected_px.push_back(res);
            end

            if (col == 0) begin
                for (int k = 0; k < 3; k++) begin
                    win[k][0] = BORDER;
                    win[k][1] = BORDER;
                end
                win[0][2] = up;
                win[1][2] = mid;
                win[2][2] = v;
            end else begin
                win = a;
            end

            upper_row[col]  = mid;
            middle_row[col] = v;

            if (slot >= last_slot) begin
                restart_image();
            end else begin
                col++;
                if (col >= w) begin
                    col = 0;
                    row_cnt++;
                end
                col_cnt = col;
            end
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_pixel(logic [PIX_W-1:0] px, logic eoi);
            t_res want;
            if (expected_px.size() == 0) begin
                report_mismatch($sformatf("unexpected word px=%0d eoi=%0b", px, eoi));
                return;
            end
            want = expected_px.pop_front();
            words_checked++;
            if (px !== want.filtered_pixel)
                report_mismatch($sformatf("filtered_pixel %0d, want %0d (word %0d)",
                                          px, want.filtered_pixel, words_checked));
            if (eoi !== want.end_of_image)
                report_mismatch($sformatf("end_of_image %0b, want %0b (word %0d)",
                                          eoi, want.end_of_image, words_checked));
            if (want.end_of_image) images_done++;
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    c3bl_pix_if pix_ch ();
    c3bl_res_if res_ch ();

    conv_scoreboard sb = new();

    int unsigned burst_left = 0;
    int unsigned quiet_cycles = 0;
    int unsigned rx_span_left = 0;
    int unsigned rx_phase = 0;
    int          rx_style = 0;

    conv3x3_blur_or_laplacian uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_pix      (pix_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // receiver back-pressure: every span picks a fresh pattern
    //   0 always ready, 1 coin toss, 2 mostly stalled, 3 fixed duty cycle
    always @(negedge clk) begin
        if (rx_span_left == 0) begin
            rx_span_left = $urandom_range(20, 80);
            rx_style     = $urandom_range(0, 3);
            rx_phase     = 0;
        end
        rx_span_left--;
        rx_phase++;
        case (rx_style)
            0:       res_ch.ready <= 1'b1;
            1:       res_ch.ready <= 1'($urandom_range(0, 1));
            2:       res_ch.ready <= ($urandom_range(0, 3) == 0);
            default: res_ch.ready <= ((rx_phase % 12) >= 7);
        endcase
    end

    // every filtered word leaving the block is checked here
    always @(posedge clk) begin
        if (rst_n && res_ch.valid && res_ch.ready)
            sb.check_pixel(res_ch.filtered_pixel, res_ch.end_of_image);
    end

    // watchdog: too long with nothing moving on either channel
    always @(posedge clk) begin
        if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: %0d cycles without a word, %0d still expected",
                     quiet_cycles, sb.expected_px.size());
            $display("conv3x3_blur_or_laplacian test failed");
            $finish;
        end
    end

    function automatic logic [PIX_W-1:0] pick_pixel(t_pix_style style);
        case (style)
            PIX_EXTREME:    return $urandom_range(0, 1) ? BORDER : '0;
            PIX_NEAR_RAILS: return $urandom_range(0, 1) ? PIX_W'($urandom_range(0, 15))
                                                        : PIX_W'($urandom_range(240, 255));
            default:        return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_dim(int unsigned hi);
        case ($urandom_range(0, 15))
            0:       return '0;         // taken as one
            1:       return CFG_W'(1);
            2:       return CFG_W'(2);
            default: return CFG_W'($urandom_range(1, hi));
        endcase
    endfunction

    // entered and left at a falling edge; the sender goes in bursts with gaps between
    task automatic send_word(input logic [PIX_W-1:0] pv, input logic fl);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                pix_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            // now and then a long stretch with no gaps at all
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        pix_ch.valid       <= 1'b1;
        pix_ch.pixel_value <= pv;
        pix_ch.flush       <= fl;
        do @(posedge clk); while (!pix_ch.ready);
        sb.note_word(pv, fl);
        @(negedge clk);
    endtask

    // full image is n_px pixels then n_drain drain words; stray flushes go in between
    task automatic send_image(input int unsigned n_px, input int unsigned n_drain,
                              input t_pix_style style);
        for (int unsigned i = 0; i < n_px; i++) begin
            if ($urandom_range(0, 19) == 0)
                send_word(PIX_W'($urandom_range(0, 255)), 1'b1);
            send_word(pick_pixel(style), 1'b0);
        end
        for (int unsigned i = 0; i < n_drain; i++) begin
            if ($urandom_range(0, 3) == 0)
                send_word(pick_pixel(style), 1'b0);
            else
                send_word(PIX_W'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    // let every expected word come out, then give the pipeline time to empty
    task automatic settle();
        pix_ch.valid <= 1'b0;
        burst_left = 0;
        @(negedge clk);
        while (sb.expected_px.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        sb.apply_reg(idx, data);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // random register setup, at least one listed register is written
    task automatic configure_random();
        bit wrote;
        wrote = 1'b0;
        if ($urandom_range(0, 9) == 0)
            write_reg(CFG_UNLISTED, CFG_W'($urandom_range(0, 2047)));
        if ($urandom_range(0, 1)) begin
            write_reg(CFG_FILTER_MODE, CFG_W'($urandom_range(0, 2047)));
            wrote = 1'b1;
        end
        if ($urandom_range(0, 3) != 0) begin
            write_reg(CFG_IMAGE_WIDTH, pick_dim(SMALL_W_MAX));
            wrote = 1'b1;
        end
        if ($urandom_range(0, 3) != 0 || !wrote)
            write_reg(CFG_IMAGE_HEIGHT, pick_dim(SMALL_H_MAX));
    endtask

    task automatic run_phase();
        int unsigned w;
        int unsigned h;
        int unsigned n_img;
        t_pix_style  style;
        settle();
        configure_random();
        w     = sb.dim_in_range(sb.width_reg, MAX_WIDTH);
        h     = sb.dim_in_range(sb.height_reg, MAX_HEIGHT);
        n_img = $urandom_range(1, 3);
        for (int unsigned k = 0; k < n_img; k++) begin
            style = t_pix_style'($urandom_range(0, 2));
            if ($urandom_range(0, 7) == 0) begin
                // cut the image short, the next register write restarts it
                send_image($urandom_range(0, w * h - 1), 0, style);
                break;
            end
            send_image(w * h, w + 1, style);
            // flush after the end of an image lands before the next one's pixels
            if ($urandom_range(0, 5) == 0)
                send_word(PIX_W'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    int unsigned n_phases;

    initial begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = CFG_FILTER_MODE;
        cfg_data           = '0;
        pix_ch.valid       = 1'b0;
        pix_ch.pixel_value = '0;
        pix_ch.flush       = 1'b0;
        res_ch.ready       = 1'b0;
        n_phases           = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        @(negedge clk);

        // directed: 3x2 blur with the mode left at its reset value
        write_reg(CFG_IMAGE_WIDTH, CFG_W'(3));
        write_reg(CFG_IMAGE_HEIGHT, CFG_W'(2));
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'hA5, 1'b1);     // flush mid-image, dropped
        send_word(8'h80, 1'b0);
        send_word(8'h01, 1'b0);
        send_word(8'hFE, 1'b0);
        send_word(8'h7F, 1'b0);
        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b1);
        send_word(8'h00, 1'b1);
        send_word(8'h3C, 1'b0);     // pixel past the end acts as a flush
        settle();

        // directed: laplacian, dark centre on bright ring clamps high, bright centre low
        write_reg(CFG_FILTER_MODE, {{(CFG_W-1){1'b0}}, MODE_LAPLACE});
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        repeat (4) send_word(8'h00, 1'b1);
        send_word(8'h11, 1'b1);     // stray flush at the start of the next image
        settle();

        // directed: zero dimensions read as a single pixel
        write_reg(CFG_IMAGE_WIDTH, '0);
        write_reg(CFG_IMAGE_HEIGHT, '0);
        send_word(8'h5A, 1'b0);
        send_word(8'h00, 1'b1);
        send_word(8'h00, 1'b1);

        // random small images in both modes with aborts and stray flushes
        while (sb.words_used < WORD_TARGET) begin
            run_phase();
            n_phases++;
        end

        // tallest column, the height write saturates
        settle();
        write_reg(CFG_FILTER_MODE, CFG_W'($urandom_range(0, 2047)));
        write_reg(CFG_IMAGE_WIDTH, CFG_W'(1));
        write_reg(CFG_IMAGE_HEIGHT, '1);
        send_image(MAX_HEIGHT, 2, PIX_NEAR_RAILS);
        settle();

        if (sb.expected_px.size() != 0)
            sb.report_mismatch($sformatf("%0d filtered words never arrived",
                                         sb.expected_px.size()));

        $display("run: %0d random phases, %0d source words used, %0d flushes dropped",
                 n_phases, sb.words_used, sb.words_ignored);
        $display("run: %0d filtered words checked over %0d complete images, %0d mismatches",
                 sb.words_checked, sb.images_done, sb.errors);
        if (sb.errors == 0)
            $display("conv3x3_blur_or_laplacian test passed");
        else
            $display("conv3x3_blur_or_laplacian test failed");
        $finish;
    end

endmodule

// File: sim.f
hdl/c3bl_pkg.sv
hdl/c3bl_pix_if.sv
hdl/c3bl_res_if.sv
hdl/c3bl_line_store.sv
hdl/conv3x3_blur_or_laplacian.sv
bench/tb_top.sv
